[sv/pps_pkg.sv]
`default_nettype none

package pps_pkg;

    // Sizing
    localparam int MAX_DIM    = 32;
    localparam int MAX_PIXELS = 1024;

    localparam int DIM_W   = $clog2(MAX_DIM);      // row / column counter
    localparam int DIMV_W  = DIM_W + 1;            // effective dimension, 1..MAX_DIM
    localparam int IDX_W   = $clog2(MAX_PIXELS);   // table address
    localparam int PROD_W  = DIM_W + DIMV_W;       // row * width + column
    localparam int FIELD_W = 10;                   // index fields on the channels
    localparam int VALUE_W = 32;
    localparam int CFG_W   = 6;
    localparam int CFG_IDX_W = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd3;

    // Opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_ELEM = 1'b1;

    // Mode / direction codes
    localparam logic MODE_FOLD  = 1'b0;
    localparam logic MODE_TABLE = 1'b1;
    localparam logic DIR_FWD    = 1'b0;
    localparam logic DIR_INV    = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [FIELD_W-1:0] entry_index;
        logic [FIELD_W-1:0] entry_target;
        logic [VALUE_W-1:0] element_value;
    } req_t;

    typedef struct packed {
        logic [FIELD_W-1:0] dest_index;
        logic [VALUE_W-1:0] out_value;
        logic               plane_last;
    } rsp_t;

    // Address generator result for the element at the current position
    typedef struct packed {
        logic               use_table;
        logic               inverse;
        logic [FIELD_W-1:0] fold_dest;
        logic [IDX_W-1:0]   tbl_addr;
        logic               plane_last;
    } pos_t;

    // 0 acts as 1, anything above MAX_DIM acts as MAX_DIM
    function automatic logic [DIMV_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [DIMV_W-1:0] ret;
        if (v == '0)
            ret = DIMV_W'(1);
        else if (32'(v) > MAX_DIM)
            ret = DIMV_W'(MAX_DIM);
        else
            ret = DIMV_W'(v);
        return ret;
    endfunction

    // Fold-in from both ends: 2r if below n, else (n-1) - (2r - n); r < n
    function automatic logic [DIM_W-1:0] fold_fwd(input logic [DIM_W-1:0] r,
                                                   input logic [DIMV_W-1:0] n);
        logic [DIMV_W:0] t2;
        logic [DIMV_W:0] n2;
        logic [DIM_W-1:0] ret;
        t2 = (DIMV_W+1)'({r, 1'b0});
        n2 = {n, 1'b0};
        if (t2 < (DIMV_W+1)'(n))
            ret = DIM_W'(t2);
        else
            ret = DIM_W'(n2 - t2 - (DIMV_W+1)'(1));
        return ret;
    endfunction

    // Inverse fold: even r -> r/2, odd r -> n-1-r/2
    function automatic logic [DIM_W-1:0] fold_inv(input logic [DIM_W-1:0] r,
                                                   input logic [DIMV_W-1:0] n);
        logic [DIM_W-1:0] half;
        logic [DIM_W-1:0] ret;
        half = r >> 1;
        if (!r[0])
            ret = half;
        else
            ret = DIM_W'(n - DIMV_W'(half) - DIMV_W'(1));
        return ret;
    endfunction

endpackage

`default_nettype wire

[sv/pps_ram.sv]
`default_nettype none

module pps_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/pps_addr_gen.sv]
`default_nettype none

module pps_addr_gen (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [pps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pps_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                           step,
    output      pps_pkg::pos_t                  pos
);

    import pps_pkg::*;

    logic              mode_reg,   mode_next;
    logic              dir_reg,    dir_next;
    logic [DIMV_W-1:0] height_reg, height_next;
    logic [DIMV_W-1:0] width_reg,  width_next;
    logic [DIM_W-1:0]  row_reg,    row_next;
    logic [DIM_W-1:0]  col_reg,    col_next;

    logic [DIM_W-1:0]  sel_row;
    logic [DIM_W-1:0]  sel_col;
    logic [PROD_W-1:0] lin;
    logic [DIMV_W-1:0] col_inc;
    logic [DIMV_W-1:0] row_inc;
    logic              last_col;
    logic              last_row;

    // Row/col positions feeding the one multiplier: raw for tables, folded otherwise
    always_comb
    begin
        if (mode_reg == MODE_TABLE)
        begin
            sel_row = row_reg;
            sel_col = col_reg;
        end
        else if (dir_reg == DIR_FWD)
        begin
            sel_row = fold_fwd(row_reg, height_reg);
            sel_col = fold_fwd(col_reg, width_reg);
        end
        else
        begin
            sel_row = fold_inv(row_reg, height_reg);
            sel_col = fold_inv(col_reg, width_reg);
        end
    end

    assign lin = PROD_W'(sel_row) * PROD_W'(width_reg) + PROD_W'(sel_col);

    assign col_inc  = DIMV_W'(col_reg) + DIMV_W'(1);
    assign row_inc  = DIMV_W'(row_reg) + DIMV_W'(1);
    assign last_col = (col_inc >= width_reg);
    assign last_row = (row_inc >= height_reg);

    assign pos.use_table  = (mode_reg == MODE_TABLE);
    assign pos.inverse    = (dir_reg == DIR_INV);
    assign pos.fold_dest  = FIELD_W'(lin);
    assign pos.tbl_addr   = IDX_W'(lin);
    assign pos.plane_last = last_col && last_row;

    always_comb
    begin
        mode_next   = mode_reg;
        dir_next    = dir_reg;
        height_next = height_reg;
        width_next  = width_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:      mode_next = cfg_data[0];
                REG_DIRECTION: dir_next  = cfg_data[0];
                REG_HEIGHT:
                begin
                    height_next = eff_dim(cfg_data);
                    row_next    = '0;
                    col_next    = '0;
                end
                REG_WIDTH:
                begin
                    width_next = eff_dim(cfg_data);
                    row_next   = '0;
                    col_next   = '0;
                end
                default: ;
            endcase
        end
        else if (step)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : DIM_W'(row_inc);
            end
            else
            begin
                col_next = DIM_W'(col_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_FOLD;
            dir_reg    <= DIR_FWD;
            height_reg <= DIMV_W'(MAX_DIM);
            width_reg  <= DIMV_W'(MAX_DIM);
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            dir_reg    <= dir_next;
            height_reg <= height_next;
            width_reg  <= width_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
        end
    end

endmodule

`default_nettype wire

[sv/plane_permute_scatter_address_top.sv]
// Plane permute scatter address generator.
//
// Request channel (req_valid/req_ready/req): opcode selects a table load or
// a plane element. A table load writes inverse[entry_index] = entry_target
// and forward[entry_target] = entry_index and gives no response. A plane
// element, taken in raster order, gives one response on rsp_valid/rsp_ready/
// rsp with its destination index in the permuted plane, the element word
// unchanged, and plane_last on the last element of each plane.
// Configuration (cfg_we/cfg_index/cfg_data): mode, direction, plane height,
// plane width; writes take effect at once. The user must write only while
// the block is idle; the block itself does not enforce it. Writing a
// dimension restarts the plane at row 0, column 0. The RAM read stage
// registers the request with the table RAM read at the accepting edge,
// then the response register takes it. Throughput: one request per cycle
// while responses are taken, set by the single read port of each table RAM.
// When the receiver stalls, one element waits in the RAM read stage and one
// in the response register; req_ready drops only once both are full.
// Reset clears mode, direction, counters and pipeline valids; dimensions
// come up at 32. Tables are undefined until loaded; no clearing pass.
`default_nettype none

module plane_permute_scatter_address_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [pps_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pps_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                           req_valid,
    output      logic                           req_ready,
    input  wire pps_pkg::req_t                  req,
    output      logic                           rsp_valid,
    input  wire logic                           rsp_ready,
    output      pps_pkg::rsp_t                  rsp
);

    import pps_pkg::*;

    pos_t pos;

    logic accept;
    logic elem_acc;
    logic load_ok;
    logic s1_adv;

    // RAM read stage
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_use_table_reg;
    logic               s1_inverse_reg;
    logic [FIELD_W-1:0] s1_fold_dest_reg;
    logic [VALUE_W-1:0] s1_value_reg;
    logic               s1_last_reg;

    // Response register
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg;

    logic [FIELD_W-1:0] fwd_rdata;
    logic [FIELD_W-1:0] inv_rdata;
    logic [FIELD_W-1:0] dest_sel;

    assign s1_adv    = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || s1_adv;
    assign accept    = req_valid && req_ready;
    assign elem_acc  = accept && (req.opcode == OP_ELEM);

    // Loads outside the table are dropped
    assign load_ok = accept && (req.opcode == OP_LOAD)
                     && (32'(req.entry_index) < MAX_PIXELS)
                     && (32'(req.entry_target) < MAX_PIXELS);

    pps_addr_gen u_addr_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (elem_acc),
        .pos       (pos)
    );

    // forward[target] = index
    pps_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (MAX_PIXELS)
    ) u_fwd_ram (
        .clk   (clk),
        .we    (load_ok),
        .waddr (IDX_W'(req.entry_target)),
        .wdata (req.entry_index),
        .re    (elem_acc),
        .raddr (pos.tbl_addr),
        .rdata (fwd_rdata)
    );

    // inverse[index] = target
    pps_ram #(
        .WIDTH (FIELD_W),
        .DEPTH (MAX_PIXELS)
    ) u_inv_ram (
        .clk   (clk),
        .we    (load_ok),
        .waddr (IDX_W'(req.entry_index)),
        .wdata (req.entry_target),
        .re    (elem_acc),
        .raddr (pos.tbl_addr),
        .rdata (inv_rdata)
    );

    // RAM read data holds while stage 1 stalls: no read is issued then
    always_comb
    begin
        if (!s1_use_table_reg)
            dest_sel = s1_fold_dest_reg;
        else if (s1_inverse_reg)
            dest_sel = inv_rdata;
        else
            dest_sel = fwd_rdata;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (elem_acc)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        rsp_valid_next = rsp_valid_reg;
        if (s1_adv)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (elem_acc)
        begin
            s1_use_table_reg <= pos.use_table;
            s1_inverse_reg   <= pos.inverse;
            s1_fold_dest_reg <= pos.fold_dest;
            s1_value_reg     <= req.element_value;
            s1_last_reg      <= pos.plane_last;
        end
        if (s1_adv)
        begin
            rsp_reg.dest_index <= dest_sel;
            rsp_reg.out_value  <= s1_value_reg;
            rsp_reg.plane_last <= s1_last_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    // Both stages full and receiver stalled: no request may enter
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && rsp_valid_reg && !rsp_ready) |-> !req_ready)
        else $error("request accepted while pipeline full");

    // An accepted element always occupies the read stage next cycle
    a_elem_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req.opcode == OP_ELEM) |=> s1_valid_reg)
        else $error("element lost at read stage");

    // A table load into an empty read stage leaves it empty
    a_load_no_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req.opcode == OP_LOAD && !s1_valid_reg)
        |=> !s1_valid_reg)
        else $error("table load produced a response");

    // A read-stage element moves into the response register
    a_s1_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> rsp_valid)
        else $error("response dropped");
`endif

endmodule

`default_nettype wire

[tb/tb_plane_permute_scatter_address_top.sv]
`default_nettype none

module tb_plane_permute_scatter_address_top;

    import pps_pkg::*;

    // Kinds of back-pressure exercised in the middle of a phase
    localparam int PRESS_NONE  = 0;
    localparam int PRESS_HOLD  = 1;   // receiver holds off for a long stretch
    localparam int PRESS_PAUSE = 2;   // sender waits until all responses are back

    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE_WAIT  = 6;  // pipeline is 2 deep; loads give no response
    localparam int RANDOM_ITEMS = 850;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors mode, direction, dimensions, the plane counters
    // and both tables; keeps the expected responses in order.
    // ------------------------------------------------------------------
    class scatter_scoreboard;
        logic               map_mode;
        logic               map_dir;
        logic [CFG_W-1:0]   height_reg;
        logic [CFG_W-1:0]   width_reg;
        int unsigned        row;
        int unsigned        col;
        logic [FIELD_W-1:0] fwd_tbl [MAX_PIXELS];
        logic [FIELD_W-1:0] inv_tbl [MAX_PIXELS];
        bit                 fwd_set [MAX_PIXELS];
        bit                 inv_set [MAX_PIXELS];
        rsp_t               pending_moves [$];
        int                 errors;

        function new();
            map_mode   = MODE_FOLD;
            map_dir    = DIR_FWD;
            height_reg = CFG_W'(MAX_DIM);
            width_reg  = CFG_W'(MAX_DIM);
            row        = 0;
            col        = 0;
            errors     = 0;
        endfunction

        // 0 behaves as 1, anything past MAX_DIM as MAX_DIM
        function int unsigned dim_of(logic [CFG_W-1:0] v);
            if (v == '0)
                return 1;
            if (int'(v) > MAX_DIM)
                return MAX_DIM;
            return int'(v);
        endfunction

        // Fold-in from both ends along one axis of size n, or its inverse for DIR_INV
        function int unsigned fold_map(int unsigned r, int unsigned n);
            if (map_dir == DIR_FWD)
            begin
                if (2 * r < n)
                    return 2 * r;
                return (n - 1) - ((2 * r) % n);
            end
            if (r % 2 == 0)
                return r / 2;
            return n - 1 - r / 2;
        endfunction

        function int unsigned table_slot();
            return (row * dim_of(width_reg) + col) % MAX_PIXELS;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_MODE:      map_mode = data[0];
                REG_DIRECTION: map_dir  = data[0];
                REG_HEIGHT:
                begin
                    height_reg = data;
                    row = 0;
                    col = 0;
                end
                REG_WIDTH:
                begin
                    width_reg = data;
                    row = 0;
                    col = 0;
                end
                default: ;
            endcase
        endfunction

        // Destination of the element at the current position; moves on
        function rsp_t step_element(req_t item);
            int unsigned h;
            int unsigned w;
            int unsigned p;
            rsp_t        res;
            h = dim_of(height_reg);
            w = dim_of(width_reg);
            if (map_mode == MODE_FOLD)
                res.dest_index = FIELD_W'(fold_map(row, h) * w + fold_map(col, w));
            else
            begin
                p = table_slot();
                res.dest_index = (map_dir == DIR_FWD) ? fwd_tbl[p] : inv_tbl[p];
            end
            res.out_value  = item.element_value;
            res.plane_last = (col + 1 >= w) && (row + 1 >= h);
            if (col + 1 >= w)
            begin
                col = 0;
                row = (row + 1 >= h) ? 0 : row + 1;
            end
            else
                col = col + 1;
            return res;
        endfunction

        function void note_request(req_t item);
            rsp_t res;
            if (item.opcode == OP_LOAD)
            begin
                // 10-bit fields can never reach MAX_PIXELS, so every load lands
                inv_tbl[item.entry_index]  = item.entry_target;
                inv_set[item.entry_index]  = 1'b1;
                fwd_tbl[item.entry_target] = item.entry_index;
                fwd_set[item.entry_target] = 1'b1;
            end
            else
            begin
                res = step_element(item);
                pending_moves.insert(pending_moves.size(), res);
            end
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (pending_moves.size() == 0)
            begin
                $display("%0t: response with nothing expected: %h", $time, got);
                errors++;
                return;
            end
            want = pending_moves.pop_front();
            if (got.dest_index !== want.dest_index)
            begin
                $display("%0t: dest_index expected %0d actual %0d",
                         $time, want.dest_index, got.dest_index);
                errors++;
            end
            if (got.out_value !== want.out_value)
            begin
                $display("%0t: out_value expected %h actual %h",
                         $time, want.out_value, got.out_value);
                errors++;
            end
            if (got.plane_last !== want.plane_last)
            begin
                $display("%0t: plane_last expected %b actual %b",
                         $time, want.plane_last, got.plane_last);
                errors++;
            end
        endfunction

        function int pending();
            return pending_moves.size();
        endfunction

        function bit close_out();
            if (pending_moves.size() != 0)
            begin
                $display("%0t: %0d responses never arrived", $time, pending_moves.size());
                errors++;
            end
            return errors == 0;
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    req_t                 req_bus   = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    rsp_t                 rsp_bus;

    scatter_scoreboard sb = new();

    int send_idle_pct = 0;   // chance of a gap before each request
    int stall_pct     = 0;   // chance the receiver is not ready in a cycle
    int hold_cycles   = 0;   // long receiver hold-off, counted down below
    int sent_items    = 0;

    plane_permute_scatter_address_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req_bus),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp_bus)
    );

    always #2 clk = ~clk;

    // Receiver: random stalls, or a solid hold-off while hold_cycles runs down.
    // hold_cycles is only raised from the stimulus at a rising edge, so this
    // falling-edge process never races with it.
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            rsp_ready = 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
            rsp_ready = ($urandom_range(99) >= stall_pct);
    end

    // Responses are checked as they are taken
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp_bus);
    end

    // Hard stop in case the block hangs
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers. Inputs move on the falling edge; the handshake is sampled
    // on the rising edge. The driver notes the request itself, so the
    // stimulus code always sees an up-to-date table and position.
    // ------------------------------------------------------------------
    task automatic send_request(input req_t item);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_bus   = item;
        req_valid = 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(item);
        sent_items++;
    endtask

    task automatic send_element(input logic [VALUE_W-1:0] value);
        req_t item;
        item.opcode        = OP_ELEM;
        item.entry_index   = FIELD_W'($urandom);
        item.entry_target  = FIELD_W'($urandom);
        item.element_value = value;
        send_request(item);
    endtask

    task automatic send_load(input logic [FIELD_W-1:0] j, input logic [FIELD_W-1:0] v);
        req_t item;
        item.opcode        = OP_LOAD;
        item.entry_index   = j;
        item.entry_target  = v;
        item.element_value = $urandom;
        send_request(item);
    endtask

    // Drop valid, then wait for every outstanding response
    task automatic wait_drained();
        @(negedge clk);
        req_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Loads give no response, so allow the pipe to empty before a write
    task automatic settle();
        wait_drained();
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Mode and direction carry random upper bits, which the block must ignore
    task automatic configure(input logic m, input logic d, input logic [CFG_W-1:0] h,
                             input logic [CFG_W-1:0] w, input bit write_dims);
        settle();
        write_reg(REG_MODE, {(CFG_W-1)'($urandom), m});
        write_reg(REG_DIRECTION, {(CFG_W-1)'($urandom), d});
        if (write_dims)
        begin
            write_reg(REG_HEIGHT, h);
            write_reg(REG_WIDTH, w);
        end
    endtask

    // In table mode, make sure the entry the next element reads was loaded.
    // Targets stay inside the plane half the time; the rest may point past it.
    task automatic fill_entry();
        int unsigned slot;
        int unsigned span;
        logic [FIELD_W-1:0] other;
        slot = sb.table_slot();
        span = sb.dim_of(sb.height_reg) * sb.dim_of(sb.width_reg);
        if ($urandom_range(1) == 0)
            other = FIELD_W'($urandom_range(span - 1));
        else
            other = FIELD_W'($urandom);
        if (sb.map_dir == DIR_FWD && !sb.fwd_set[slot])
            send_load(other, FIELD_W'(slot));
        if (sb.map_dir == DIR_INV && !sb.inv_set[slot])
            send_load(FIELD_W'(slot), other);
    endtask

    function automatic logic [CFG_W-1:0] pick_dim();
        if ($urandom_range(99) < 12)
        begin
            case ($urandom_range(5))
                0:       return CFG_W'(0);
                1:       return CFG_W'(1);
                2:       return CFG_W'(31);
                3:       return CFG_W'(32);
                4:       return CFG_W'(33);
                default: return CFG_W'(63);
            endcase
        end
        return CFG_W'($urandom_range(1, 8));
    endfunction

    task automatic run_phase(input int n_elem, input int pressure);
        int i;
        for (i = 0; i < n_elem; i++)
        begin
            if (i == n_elem / 2 && pressure == PRESS_HOLD)
                hold_cycles = HOLD_CYCLES;
            if (i == n_elem / 2 && pressure == PRESS_PAUSE)
                wait_drained();
            // stray loads keep rewriting the tables under both modes
            if ($urandom_range(99) < 12)
                send_load(FIELD_W'($urandom), FIELD_W'($urandom));
            if (sb.map_mode == MODE_TABLE)
                fill_entry();
            send_element($urandom);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int phase;
        int press;
        bit dims;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset configuration: fold map, forward, 32 x 32
        send_element(32'h0000_0000);
        send_element(32'hFFFF_FFFF);
        send_element(32'hA5A5_5A5A);

        // Entry extremes; forward[0] and inverse[0] now hold 1023, past any
        // 1 x 1 plane, so the table value comes out as is
        send_load(FIELD_W'(0), FIELD_W'(1023));
        send_load(FIELD_W'(1023), FIELD_W'(0));
        configure(MODE_TABLE, DIR_FWD, CFG_W'(1), CFG_W'(1), 1'b1);
        send_element($urandom);
        settle();
        write_reg(REG_DIRECTION, CFG_W'(DIR_INV));
        send_element($urandom);

        // Zero height acts as 1, 63 wide acts as 32; inverse fold along a row
        configure(MODE_FOLD, DIR_INV, CFG_W'(0), CFG_W'(63), 1'b1);
        repeat (4) send_element($urandom);

        // Height past the limit, width zero
        configure(MODE_FOLD, DIR_FWD, CFG_W'(33), CFG_W'(0), 1'b1);
        repeat (3) send_element($urandom);

        // One full small plane and the wrap into the next
        configure(MODE_FOLD, DIR_FWD, CFG_W'(3), CFG_W'(2), 1'b1);
        repeat (7) send_element($urandom);

        // Random phases, rotating through the idling profiles
        phase = 0;
        while (sent_items < RANDOM_ITEMS)
        begin
            dims = (phase == 0) || ($urandom_range(99) < 80);
            configure(1'($urandom_range(1)), 1'($urandom_range(1)), pick_dim(), pick_dim(),
                      dims);
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 59;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 59;
                end
                default:
                begin
                    send_idle_pct = 19;
                    stall_pct = 19;
                end
            endcase
            if (phase % 5 == 2)
                press = PRESS_HOLD;
            else if (phase % 5 == 4)
                press = PRESS_PAUSE;
            else
                press = PRESS_NONE;
            run_phase($urandom_range(15, 50), press);
            phase++;
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.close_out())
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

[plane_permute_scatter_address_top.f]
sv/pps_pkg.sv
sv/pps_ram.sv
sv/pps_addr_gen.sv
sv/plane_permute_scatter_address_top.sv
tb/tb_plane_permute_scatter_address_top.sv
